[rtl/core/tlik_pkg.sv]
// ----------------------------------------------------------------------------
// tlik_pkg: shared types and constants for the two-link IK unit
// Field widths, internal datapath widths, register indexes and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package tlik_pkg;

  // field widths
  localparam int COORD_W    = 16;
  localparam int LEN_W      = 15;
  localparam int SHO_W      = 16;
  localparam int ELB_W      = 15;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_LENGTH  = 3'd3;
  localparam logic [LEN_W-1:0]     LEN_RESET        = 15'd1024;

  // internal widths
  localparam int D_W         = COORD_W + 1;   // target minus base
  localparam int N_W         = 36;            // n and k1
  localparam int LIM_W       = 31;            // 2*l1*l2 and sqrt result
  localparam int SQ_W        = 63;            // square-root remainder
  localparam int SQ_N        = 31;            // square-root cells
  localparam int NORM_W      = 64;            // normalizer word
  localparam int NORM_STAGES = 6;             // shifts of 32,16,8,4,2,1
  localparam int MAG_W       = 30;            // CORDIC start magnitude
  localparam int CX_W        = 33;            // CORDIC x/y
  localparam int Z_W         = 35;            // Q2.30 angle with headroom
  localparam int ATAN_N      = 24;

  // defaults for top-level parameters
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 12;

  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sh0C90FDAA2;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } flags_t;

  // per-item data carried beside the square-root chain
  typedef struct packed {
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [N_W-1:0] n;
    logic signed [N_W-1:0] k1;
    logic                  up;
    logic                  reach;
  } side_t;

  // per-item data carried beside the normalizer and CORDIC chains
  typedef struct packed {
    logic        reach;
    logic        up;
    flags_t [2:0] fl;
  } post_t;

  typedef struct packed {
    logic                    reachable;
    logic signed [SHO_W-1:0] shoulder;
    logic signed [ELB_W-1:0] elbow;
  } result_t;

  // arctan(2^-i) in Q2.30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/tlik_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// tlik_sqrt_cell: one step of the integer square root
// Tries bit 4^K against the remainder and hands remainder and root onward.
// ----------------------------------------------------------------------------
module tlik_sqrt_cell import tlik_pkg::*; #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] rem_i,
  input  logic [SQ_W-1:0] res_i,
  output logic [SQ_W-1:0] rem_r,
  output logic [SQ_W-1:0] res_r
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

  logic [SQ_W-1:0] trial;
  logic [SQ_W-1:0] rem_nxt;
  logic [SQ_W-1:0] res_nxt;

  // compare and subtract
  always_comb begin
    trial = res_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt = rem_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      rem_nxt = rem_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/core/tlik_norm_cell.sv]
// ----------------------------------------------------------------------------
// tlik_norm_cell: one step of the vector normalizer
// Shifts both components left by SHIFT when the top SHIFT bits are clear.
// ----------------------------------------------------------------------------
module tlik_norm_cell import tlik_pkg::*; #(
  parameter int SHIFT = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NORM_W-1:0] ax_i,
  input  logic [NORM_W-1:0] ay_i,
  output logic [NORM_W-1:0] ax_r,
  output logic [NORM_W-1:0] ay_r
);

  logic [NORM_W-1:0] both;
  logic [NORM_W-1:0] ax_nxt;
  logic [NORM_W-1:0] ay_nxt;

  // leading-zero test on the joint magnitude
  always_comb begin
    both = ax_i | ay_i;
    if (both[NORM_W-1 -: SHIFT] == '0) begin
      ax_nxt = ax_i << SHIFT;
      ay_nxt = ay_i << SHIFT;
    end else begin
      ax_nxt = ax_i;
      ay_nxt = ay_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end
  end

endmodule

[rtl/core/tlik_cordic_cell.sv]
// ----------------------------------------------------------------------------
// tlik_cordic_cell: one vectoring CORDIC iteration
// Rotates toward the x axis by arctan(2^-STEP) and accumulates the angle.
// ----------------------------------------------------------------------------
module tlik_cordic_cell import tlik_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [CX_W-1:0] cx_i,
  input  logic signed [CX_W-1:0] cy_i,
  input  logic signed [Z_W-1:0]  z_i,
  output logic signed [CX_W-1:0] cx_r,
  output logic signed [CX_W-1:0] cy_r,
  output logic signed [Z_W-1:0]  z_r
);

  localparam logic signed [Z_W-1:0] ATAN = $signed(Z_W'(atan_q30(STEP)));

  logic signed [CX_W-1:0] cx_nxt;
  logic signed [CX_W-1:0] cy_nxt;
  logic signed [Z_W-1:0]  z_nxt;

  // direction follows the sign of y
  always_comb begin
    if (!cy_i[CX_W-1]) begin
      cx_nxt = cx_i + (cy_i >>> STEP);
      cy_nxt = cy_i - (cx_i >>> STEP);
      z_nxt  = z_i + ATAN;
    end else begin
      cx_nxt = cx_i - (cy_i >>> STEP);
      cy_nxt = cy_i + (cx_i >>> STEP);
      z_nxt  = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      z_r  <= z_nxt;
    end
  end

endmodule

[rtl/core/two_link_inverse_kinematics_unit.sv]
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_unit: joint angles of a two-link planar arm
// Squares and reach test, a square-root cell chain, then three normalizer
// and CORDIC chains for atan2, and a two-entry output skid buffer.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   target_x, target_y, elbow_up
//   out_     output     out_valid/out_stall reachable, shoulder_angle,
//                                           elbow_angle
//   cfg_     input      cfg_valid/cfg_ready index, data
//
// One item per cycle while the skid has room. The 31-cell square-root
// chain and the CORDIC iteration chain set the depth. Reset clears the
// stage valid bits, the skid buffer and the base registers, and sets the
// link lengths to LEN_RESET. The skid holds two results; when full, the
// whole pipeline holds and in_stall is high. cfg_ready is always high.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_unit import tlik_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [COORD_W-1:0] in_target_x,
  input  logic signed [COORD_W-1:0] in_target_y,
  input  logic                    in_elbow_up,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_reachable,
  output logic signed [SHO_W-1:0] out_shoulder_angle,
  output logic signed [ELB_W-1:0] out_elbow_angle,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int LAT     = 5 + SQ_N + 1 + NORM_STAGES + CORDIC_STEPS + 1;
  localparam int POST_N  = NORM_STAGES + CORDIC_STEPS;
  localparam int RSH     = 30 - ANGLE_FRAC_BITS;
  localparam int SHO_MAX = 2 ** (SHO_W - 1) - 1;
  localparam int SHO_MIN = -(2 ** (SHO_W - 1));
  localparam int ELB_MAX = 2 ** (ELB_W - 1) - 1;
  localparam int ELB_MIN = -(2 ** (ELB_W - 1));
  localparam logic signed [Z_W:0] HALF = (Z_W + 1)'(1) << (RSH - 1);

  // configuration registers
  logic signed [COORD_W-1:0] base_x_r, base_y_r;
  logic [LEN_W-1:0]          l1_r, l2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= '0;
      base_y_r <= '0;
      l1_r     <= LEN_RESET;
      l2_r     <= LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_X:       base_x_r <= $signed(cfg_data);
        REG_BASE_Y:       base_y_r <= $signed(cfg_data);
        REG_UPPER_LENGTH: l1_r     <= cfg_data[LEN_W-1:0];
        REG_FORE_LENGTH:  l2_r     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: all stages move together while the skid has room
  logic [1:0]     cnt_r;
  logic           en, acc, push, pop;
  logic [LAT-1:0] vld_r;

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], acc};
    end
  end

  // stage 1: offsets from the base
  logic signed [D_W-1:0] dx1_r, dy1_r;
  logic                  up1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= D_W'(in_target_x) - D_W'(base_x_r);
      dy1_r <= D_W'(in_target_y) - D_W'(base_y_r);
      up1_r <= in_elbow_up;
    end
  end

  // stage 2: squares and link product
  logic signed [2*D_W-1:0]   dxsq2_r, dysq2_r;
  logic [2*LEN_W-1:0]        l1sq2_r, l2sq2_r, l1l22_r;
  logic signed [D_W-1:0]     dx2_r, dy2_r;
  logic                      up2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dxsq2_r <= dx1_r * dx1_r;
      dysq2_r <= dy1_r * dy1_r;
      l1sq2_r <= l1_r * l1_r;
      l2sq2_r <= l2_r * l2_r;
      l1l22_r <= l1_r * l2_r;
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      up2_r   <= up1_r;
    end
  end

  // stage 3: n, k1 and the reach test
  logic signed [N_W-1:0] n_nxt, k1_nxt;
  logic [N_W-1:0]        an_nxt;
  logic [LIM_W-1:0]      lim_nxt;
  logic                  reach_nxt;
  logic signed [N_W-1:0] n3_r, k13_r;
  logic [LIM_W-1:0]      lim3_r, anc3_r;
  logic                  reach3_r, up3_r;
  logic signed [D_W-1:0] dx3_r, dy3_r;

  always_comb begin
    n_nxt     = N_W'(dxsq2_r) + N_W'(dysq2_r)
              - $signed(N_W'(l1sq2_r)) - $signed(N_W'(l2sq2_r));
    k1_nxt    = $signed(N_W'({l1sq2_r, 1'b0})) + n_nxt;
    lim_nxt   = {l1l22_r, 1'b0};
    an_nxt    = n_nxt[N_W-1] ? N_W'(-n_nxt) : N_W'(n_nxt);
    reach_nxt = (an_nxt <= N_W'(lim_nxt));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r     <= n_nxt;
      k13_r    <= k1_nxt;
      lim3_r   <= lim_nxt;
      anc3_r   <= reach_nxt ? an_nxt[LIM_W-1:0] : '0;
      reach3_r <= reach_nxt;
      up3_r    <= up2_r;
      dx3_r    <= dx2_r;
      dy3_r    <= dy2_r;
    end
  end

  // stage 4: squares of the limit and of |n|
  logic [2*LIM_W-1:0] limsq4_r, ansq4_r;
  side_t              side4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      limsq4_r      <= lim3_r * lim3_r;
      ansq4_r       <= anc3_r * anc3_r;
      side4_r.dx    <= dx3_r;
      side4_r.dy    <= dy3_r;
      side4_r.n     <= n3_r;
      side4_r.k1    <= k13_r;
      side4_r.up    <= up3_r;
      side4_r.reach <= reach3_r;
    end
  end

  // stage 5: radicand; side data then follows the root chain
  logic [SQ_W-1:0] rem5_r;
  side_t           side_pipe_r [SQ_N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem5_r         <= SQ_W'(limsq4_r - ansq4_r);
      side_pipe_r[0] <= side4_r;
      for (int k = 0; k < SQ_N; k++) begin
        side_pipe_r[k+1] <= side_pipe_r[k];
      end
    end
  end

  // square-root cell chain
  logic [SQ_W-1:0] rem_w [SQ_N+1];
  logic [SQ_W-1:0] res_w [SQ_N+1];

  assign rem_w[0] = rem5_r;
  assign res_w[0] = '0;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    tlik_sqrt_cell #(.K(SQ_N - 1 - k)) u_cell (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_w[k]),
      .res_i (res_w[k]),
      .rem_r (rem_w[k+1]),
      .res_r (res_w[k+1])
    );
  end

  // atan2 operand setup: magnitudes and quadrant flags for three lanes
  function automatic logic [N_W-1:0] abs_n(input logic signed [N_W-1:0] v);
    return v[N_W-1] ? N_W'(-v) : N_W'(v);
  endfunction

  logic [LIM_W-1:0]  s_w;
  side_t             sp;
  logic [NORM_W-1:0] ax_nxt [3];
  logic [NORM_W-1:0] ay_nxt [3];
  post_t             post_nxt;
  logic [NORM_W-1:0] pre_ax_r [3];
  logic [NORM_W-1:0] pre_ay_r [3];
  post_t             post_pipe_r [POST_N+1];

  always_comb begin
    s_w = res_w[SQ_N][LIM_W-1:0];
    sp  = side_pipe_r[SQ_N];
    // elbow: atan2(s, n)
    ax_nxt[0] = NORM_W'(abs_n(sp.n));
    ay_nxt[0] = NORM_W'(s_w);
    // target direction: atan2(dy, dx)
    ax_nxt[1] = NORM_W'(abs_n(N_W'(sp.dx)));
    ay_nxt[1] = NORM_W'(abs_n(N_W'(sp.dy)));
    // offset: atan2(+-s, k1)
    ax_nxt[2] = NORM_W'(abs_n(sp.k1));
    ay_nxt[2] = NORM_W'(s_w);
    post_nxt.reach      = sp.reach;
    post_nxt.up         = sp.up;
    post_nxt.fl[0].xneg = sp.n[N_W-1];
    post_nxt.fl[0].yneg = 1'b0;
    post_nxt.fl[1].xneg = sp.dx[D_W-1];
    post_nxt.fl[1].yneg = sp.dy[D_W-1];
    post_nxt.fl[2].xneg = sp.k1[N_W-1];
    post_nxt.fl[2].yneg = sp.up && (s_w != '0);
    for (int l = 0; l < 3; l++) begin
      post_nxt.fl[l].zero = (ax_nxt[l] == '0) && (ay_nxt[l] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        pre_ax_r[l] <= ax_nxt[l];
        pre_ay_r[l] <= ay_nxt[l];
      end
      post_pipe_r[0] <= post_nxt;
      for (int k = 0; k < POST_N; k++) begin
        post_pipe_r[k+1] <= post_pipe_r[k];
      end
    end
  end

  // three normalizer + CORDIC lanes
  logic signed [Z_W-1:0] zfin [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [NORM_W-1:0]      ax_w [NORM_STAGES+1];
    logic [NORM_W-1:0]      ay_w [NORM_STAGES+1];
    logic signed [CX_W-1:0] cx_w [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cy_w [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  z_w  [CORDIC_STEPS+1];

    assign ax_w[0] = pre_ax_r[l];
    assign ay_w[0] = pre_ay_r[l];

    for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
      tlik_norm_cell #(.SHIFT(1 << (NORM_STAGES - 1 - j))) u_cell (
        .clk  (clk),
        .en   (en),
        .ax_i (ax_w[j]),
        .ay_i (ay_w[j]),
        .ax_r (ax_w[j+1]),
        .ay_r (ay_w[j+1])
      );
    end

    // leading one now at the top; keep 30 bits
    assign cx_w[0] = $signed(CX_W'(ax_w[NORM_STAGES][NORM_W-1 -: MAG_W]));
    assign cy_w[0] = $signed(CX_W'(ay_w[NORM_STAGES][NORM_W-1 -: MAG_W]));
    assign z_w[0]  = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      tlik_cordic_cell #(.STEP(i)) u_cell (
        .clk  (clk),
        .en   (en),
        .cx_i (cx_w[i]),
        .cy_i (cy_w[i]),
        .z_i  (z_w[i]),
        .cx_r (cx_w[i+1]),
        .cy_r (cy_w[i+1]),
        .z_r  (z_w[i+1])
      );
    end

    assign zfin[l] = z_w[CORDIC_STEPS];
  end

  // quadrant mapping
  function automatic logic signed [Z_W-1:0] map_z(input logic signed [Z_W-1:0] z,
                                                  input flags_t f);
    logic signed [Z_W-1:0] t;
    t = f.xneg ? PI_Q30 - z : z;
    t = f.yneg ? -t : t;
    return f.zero ? '0 : t;
  endfunction

  logic signed [Z_W-1:0] za_r, zb_r, zc_r;
  logic                  reach_m_r, up_m_r;
  post_t                 pl;

  assign pl = post_pipe_r[POST_N];

  always_ff @(posedge clk) begin
    if (en) begin
      za_r      <= map_z(zfin[0], pl.fl[0]);
      zb_r      <= map_z(zfin[1], pl.fl[1]);
      zc_r      <= map_z(zfin[2], pl.fl[2]);
      reach_m_r <= pl.reach;
      up_m_r    <= pl.up;
    end
  end

  // rounding and saturation
  function automatic logic signed [Z_W:0] rnd(input logic signed [Z_W:0] v);
    return (v + HALF) >>> RSH;
  endfunction

  logic signed [Z_W:0] zd, sh_rnd, el_rnd, el_sgn;
  result_t             res_nxt;

  always_comb begin
    zd     = (Z_W + 1)'(zb_r) - (Z_W + 1)'(zc_r);
    sh_rnd = rnd(zd);
    el_rnd = rnd((Z_W + 1)'(za_r));
    el_sgn = up_m_r ? -el_rnd : el_rnd;
    res_nxt.reachable = reach_m_r;
    if (!reach_m_r) begin
      res_nxt.shoulder = '0;
      res_nxt.elbow    = '0;
    end else begin
      if (sh_rnd > SHO_MAX)      res_nxt.shoulder = SHO_W'(SHO_MAX);
      else if (sh_rnd < SHO_MIN) res_nxt.shoulder = SHO_W'(SHO_MIN);
      else                       res_nxt.shoulder = sh_rnd[SHO_W-1:0];
      if (el_sgn > ELB_MAX)      res_nxt.elbow = ELB_W'(ELB_MAX);
      else if (el_sgn < ELB_MIN) res_nxt.elbow = ELB_W'(ELB_MIN);
      else                       res_nxt.elbow = el_sgn[ELB_W-1:0];
    end
  end

  // two-entry output skid
  result_t ent_r [2];
  logic    wr_ptr_r, rd_ptr_r;
  result_t head;

  assign push = en && vld_r[LAT-1];
  assign pop  = (cnt_r != 2'd0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= res_nxt;
    end
  end

  assign head               = ent_r[rd_ptr_r];
  assign out_valid          = (cnt_r != 2'd0);
  assign out_reachable      = head.reachable;
  assign out_shoulder_angle = head.shoulder;
  assign out_elbow_angle    = head.elbow;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("skid count out of range");

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reachable) |->
      (out_shoulder_angle == '0) && (out_elbow_angle == '0))
    else $error("unreachable item with nonzero angles");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("skid count not decremented on pop");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |=> $stable(vld_r))
    else $error("pipeline moved while skid full");

endmodule

[bench/two_link_inverse_kinematics_unit_test.sv]
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_unit_test: self-checking bench for the IK unit
// Drives target points through the in_ channel under random idling, predicts
// reachability and joint angles with a bit-exact CORDIC model, and checks
// every out_ item against the oldest prediction. Several register settings,
// the extremes among them, are written while the pipeline is empty.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_unit_test;
  import tlik_pkg::*;

  localparam int STEPS     = CORDIC_STEPS_DEF;
  localparam int FRAC      = ANGLE_FRAC_BITS_DEF;
  localparam int LATENCY   = 44 + STEPS;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic                      up;
  } target_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [COORD_W-1:0] in_target_x, in_target_y;
  logic in_elbow_up;
  logic out_valid, out_stall, out_reachable;
  logic signed [SHO_W-1:0] out_shoulder_angle;
  logic signed [ELB_W-1:0] out_elbow_angle;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  two_link_inverse_kinematics_unit uut (.*);

  // predictor's copy of the registers
  logic signed [15:0] arm_bx, arm_by;
  logic [14:0] arm_l1, arm_l2;

  target_t pending_targets[$];
  result_t expected_angles[$];
  int errors;
  int idle_pct;       // percentage of idle cycles on both sides
  bit hold_rx;        // long receiver hold-off request
  int hold_left;
  bit done;
  int quiet_cycles;
  bit in_acc;         // item taken at the last rising edge

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // -- bit-exact atan2 in Q2.30 ---------------------------------------------
  function automatic longint atan2_fixed(longint y, longint x);
    longint ax, ay, cx, cy, z, nx;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    z = 0;
    if (ax == 0 && ay == 0) return 0;
    while ((ax | ay) >= (64'sd1 << 30)) begin
      ax = ax >>> 1;
      ay = ay >>> 1;
    end
    while ((ax | ay) < (64'sd1 << 29)) begin
      ax = ax <<< 1;
      ay = ay <<< 1;
    end
    cx = ax;
    cy = ay;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += longint'(atan_q30(i));
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= longint'(atan_q30(i));
      end
      cx = nx;
    end
    if (x < 0) z = longint'(PI_Q30) - z;
    if (y < 0) z = -z;
    return z;
  endfunction

  function automatic longint round_q30(longint z);
    return (z + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  // floor square root of an unsigned 64-bit value
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic result_t solve_arm(target_t t);
    result_t r;
    longint dx, dy, l1, l2, n, lim, an, s, el, sh;
    dx = longint'(t.tx) - longint'(arm_bx);
    dy = longint'(t.ty) - longint'(arm_by);
    l1 = longint'(arm_l1);
    l2 = longint'(arm_l2);
    n = dx * dx + dy * dy - l1 * l1 - l2 * l2;
    lim = 2 * l1 * l2;
    an = n < 0 ? -n : n;
    r = '0;
    if (an > lim) return r;
    s = longint'(floor_sqrt(longint'(lim * lim - an * an)));
    el = round_q30(atan2_fixed(s, n));
    if (t.up) begin
      el = -el;
      s = -s;
    end
    sh = round_q30(atan2_fixed(dy, dx) - atan2_fixed(s, 2 * l1 * l1 + n));
    if (sh < -32768) sh = -32768;
    if (sh > 32767) sh = 32767;
    if (el < -16384) el = -16384;
    if (el > 16383) el = 16383;
    r.reachable = 1'b1;
    r.shoulder = sh[SHO_W-1:0];
    r.elbow = el[ELB_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // -- driver: feeds pending targets, the front one is on the port ----------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (in_valid) void'(pending_targets.pop_front());
      if (pending_targets.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        target_t t;
        t = pending_targets[0];
        in_valid <= 1'b1;
        in_target_x <= t.tx;
        in_target_y <= t.ty;
        in_elbow_up <= t.up;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted items get their predictions at the accepting edge
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_angles.push_back(solve_arm('{in_target_x, in_target_y, in_elbow_up}));
  end

  // -- receiver stall, with an optional long hold-off -----------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_rx && hold_left == 0) begin
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (hold_left == 1) hold_left <= 0;
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // -- monitor ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        result_t e;
        e = expected_angles.pop_front();
        if (out_reachable !== e.reachable)
          report_mismatch("reachable", out_reachable, e.reachable);
        if (out_shoulder_angle !== e.shoulder)
          report_mismatch("shoulder_angle", out_shoulder_angle, e.shoulder);
        if (out_elbow_angle !== e.elbow)
          report_mismatch("elbow_angle", out_elbow_angle, e.elbow);
      end
    end
  end

  // -- watchdog on handshake progress ---------------------------------------
  always @(posedge clk) begin
    if (!rst_n || done || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("two_link_inverse_kinematics_unit test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_X:       arm_bx = val;
      REG_BASE_Y:       arm_by = val;
      REG_UPPER_LENGTH: arm_l1 = val[14:0];
      REG_FORE_LENGTH:  arm_l2 = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipe();
    while (pending_targets.size() != 0 || in_valid || expected_angles.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic setup_arm(logic [15:0] bx, logic [15:0] by, logic [14:0] l1,
                           logic [14:0] l2);
    drain_pipe();
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Y, by);
    write_reg(REG_UPPER_LENGTH, {1'b0, l1});
    write_reg(REG_FORE_LENGTH, {1'b0, l2});
  endtask

  // mostly reachable points: a random point on the disc around the base
  function automatic target_t near_target();
    target_t t;
    longint r, ang_x, ang_y, reach;
    reach = longint'(arm_l1) + longint'(arm_l2);
    r = $urandom_range(0, 1100) * reach / 1000;
    ang_x = longint'($urandom_range(0, 2000)) - 1000;
    ang_y = longint'($urandom_range(0, 2000)) - 1000;
    t.tx = 16'(longint'(arm_bx) + ang_x * r / 1415);
    t.ty = 16'(longint'(arm_by) + ang_y * r / 1415);
    t.up = 1'($urandom_range(1));
    return t;
  endfunction

  task automatic random_block(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75)
        pending_targets.push_back(near_target());
      else
        pending_targets.push_back('{16'($urandom), 16'($urandom), 1'($urandom)});
    end
  endtask

  initial begin
    errors = 0;
    idle_pct = 25;
    hold_rx = 0;
    done = 0;
    rst_n = 0;
    in_valid = 0;
    in_target_x = '0;
    in_target_y = '0;
    in_elbow_up = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    arm_bx = 0;
    arm_by = 0;
    arm_l1 = LEN_RESET;
    arm_l2 = LEN_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed points under reset values: origin, full reach, both elbows,
    // coordinate extremes, fold-back with zero s
    pending_targets.push_back('{16'sd0, 16'sd0, 1'b0});
    pending_targets.push_back('{16'sd0, 16'sd0, 1'b1});
    pending_targets.push_back('{16'sd2048, 16'sd0, 1'b0});
    pending_targets.push_back('{16'sd2048, 16'sd0, 1'b1});
    pending_targets.push_back('{-16'sd2048, 16'sd0, 1'b1});
    pending_targets.push_back('{16'sd0, -16'sd2048, 1'b0});
    pending_targets.push_back('{16'sd1000, 16'sd1000, 1'b0});
    pending_targets.push_back('{-16'sd1000, -16'sd700, 1'b1});
    pending_targets.push_back('{16'sd2049, 16'sd0, 1'b0});
    pending_targets.push_back('{16'sh7FFF, 16'sh7FFF, 1'b1});
    pending_targets.push_back('{-16'sh8000, -16'sh8000, 1'b0});
    pending_targets.push_back('{-16'sh8000, 16'sh7FFF, 1'b1});
    pending_targets.push_back('{16'sd1, 16'sd0, 1'b1});

    // unequal links: inner limit and zero-s fold with elbow up
    setup_arm(16'sd0, 16'sd0, 15'd1000, 15'd400);
    pending_targets.push_back('{16'sd600, 16'sd0, 1'b1});
    pending_targets.push_back('{-16'sd600, 16'sd0, 1'b0});
    pending_targets.push_back('{16'sd599, 16'sd0, 1'b0});
    pending_targets.push_back('{16'sd0, 16'sd1400, 1'b1});

    // extreme registers: longest links, minimum links, corner bases
    setup_arm(16'h8000, 16'h7FFF, 15'h7FFF, 15'h7FFF);
    pending_targets.push_back('{16'sh7FFF, -16'sh8000, 1'b0});
    pending_targets.push_back('{16'sh7FFF, -16'sh8000, 1'b1});
    pending_targets.push_back('{-16'sh8000, 16'sh7FFF, 1'b0});
    setup_arm(16'h7FFF, 16'h8000, 15'd1, 15'd1);
    pending_targets.push_back('{16'sh7FFF, -16'sh8000, 1'b0});
    pending_targets.push_back('{16'sh7FFF, -16'sh7FFE, 1'b1});
    pending_targets.push_back('{16'sh7FFD, -16'sh8000, 1'b0});
    // ignored register index
    drain_pipe();
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd7, 16'h1234);

    // random phases over several settings
    setup_arm(16'h0000, 16'h0000, 15'd1024, 15'd1024);
    idle_pct = 0;                                  // no idling at all
    random_block(80);
    setup_arm(16'($urandom), 16'($urandom), 15'($urandom_range(1, 32767)),
              15'($urandom_range(1, 32767)));
    idle_pct = 25;
    random_block(120);
    // long receiver hold-off while the sender keeps offering
    while (pending_targets.size() > 60) @(posedge clk);
    hold_rx = 1;
    @(posedge clk);
    @(posedge clk);
    hold_rx = 0;
    setup_arm(16'sd300, -16'sd200, 15'd5000, 15'd200);
    random_block(120);
    setup_arm(16'($urandom), 16'($urandom), 15'($urandom_range(1, 2000)),
              15'($urandom_range(1, 32767)));
    random_block(120);
    // sender pause until the pipeline is empty, then more
    drain_pipe();
    setup_arm(-16'sd4000, 16'sd4000, 15'h7FFF, 15'd1);
    random_block(90);

    drain_pipe();
    done = 1;
    if (errors == 0)
      $display("two_link_inverse_kinematics_unit test passed");
    else
      $display("two_link_inverse_kinematics_unit test failed");
    $finish;
  end
endmodule
